>>> rtl/c2i_pkg.sv
// ----------------------------------------------------------------------------
// c2i_pkg
// Shared types and constants of the 1-D col2im overlap-add block.
// ----------------------------------------------------------------------------
`default_nettype none

package c2i_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int COL_W      = 10;
    localparam int CH_W       = 6;
    localparam int TAP_W      = 6;
    localparam int TIME_W     = 16;
    localparam int SUM_W      = 22;

    localparam int STRIDE_W   = 7;
    localparam int PAD_W      = 6;
    localparam int KERN_W     = 7;
    localparam int CHN_W      = 7;
    localparam int NCOL_W     = 11;
    localparam int LEN_W      = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;

    localparam int STRIDE_MAX = 64;

    localparam int POS_W      = 17;
    localparam int ROW_W      = KERN_W + CHN_W;
    localparam int CS_W       = NCOL_W + STRIDE_W;
    localparam int FULL_W     = NCOL_W + ROW_W;
    localparam int ACC_W      = 24;
    localparam int DIV_CNT_W  = 5;

    localparam logic signed [ACC_W-1:0] ACC_SUM_HI = ACC_W'(2 ** (SUM_W - 1) - 1);
    localparam logic signed [ACC_W-1:0] ACC_SUM_LO = ACC_W'(-(2 ** (SUM_W - 1)));

    localparam logic MODE_LOAD    = 1'b0;
    localparam logic MODE_COMPUTE = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STRIDE      = 3'd0,
        CFG_PADDING     = 3'd1,
        CFG_KERNEL_SIZE = 3'd2,
        CFG_CHANNELS    = 3'd3,
        CFG_NUM_COLUMNS = 3'd4,
        CFG_OUT_LENGTH  = 3'd5
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_DIV,
        S_MUL,
        S_ADDR,
        S_RUN,
        S_DRAIN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic                       mode;
        logic signed [SAMPLE_W-1:0] sample;
        logic [COL_W-1:0]           column_index;
        logic [CH_W-1:0]            channel;
        logic [TAP_W-1:0]           tap;
        logic [TIME_W-1:0]          out_time;
    } t_in_item;

    typedef struct packed {
        logic signed [SUM_W-1:0] sum;
        logic                    range_error;
    } t_out_item;

endpackage

`default_nettype wire

>>> rtl/c2i_div.sv
// ----------------------------------------------------------------------------
// c2i_div
// Bit-serial restoring divider: output position over stride, one bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module c2i_div import c2i_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [POS_W-1:0]    i_dividend,
    input  logic [STRIDE_W-1:0] i_divisor,
    output logic                o_done,
    output logic [POS_W-1:0]    o_quot
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [STRIDE_W-1:0]  r_rem;
    logic [POS_W-1:0]     r_quo;

    logic [STRIDE_W:0]    trial;
    logic [STRIDE_W:0]    diff;
    logic                 ge;

    assign trial = {r_rem, r_quo[POS_W-1]};
    assign diff  = trial - {1'b0, i_divisor};
    assign ge    = (trial >= {1'b0, i_divisor});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= DIV_CNT_W'(POS_W - 1);
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end else begin
                r_cnt  <= r_cnt - 1'b1;
                r_done <= 1'b0;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= ge ? diff[STRIDE_W-1:0] : trial[STRIDE_W-1:0];
            r_quo <= {r_quo[POS_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

    a_rem_below_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_rem < i_divisor))
        else $error("divider remainder not below divisor");

    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy)
        else $error("divider done while busy");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> (r_busy && !r_done))
        else $error("divider did not start");

endmodule

`default_nettype wire

>>> rtl/col2im_1d_overlap_add.sv
// ----------------------------------------------------------------------------
// col2im_1d_overlap_add
// 1-D col2im overlap-add over a column store held in one synchronous memory.
//
// Input channel (i_in_valid / o_in_stall / i_in_item): mode 0 loads one
// column sample into the store, mode 1 asks for one output sample. Output
// channel (o_out_valid / i_out_stall / o_out_item): one item per compute.
// Configuration is a plain write port, to be written by the user only while
// the block is idle; the block itself does not enforce this. A load passes
// through S_LOAD and gives no output. A compute goes through the 17-step
// bit-serial stride divider (S_DIV), then S_MUL and S_ADDR, then reads one
// stored tap a cycle through the single memory read port for each of its n
// covering columns (at most ceil(kernel_size / stride)), then S_DRAIN, and
// its result enters the output register from S_DONE. A bad request goes
// straight to S_DONE for its error item. One item is in work at a time; the
// next is taken the cycle after the result enters the output register.
// Reset returns the configuration registers to their defaults and empties the
// output register; the store keeps no reset value. While the receiver stalls,
// the output item holds and a finished compute waits until the register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module col2im_1d_overlap_add import c2i_pkg::*; #(
    parameter int MEM_DEPTH    = 4096,
    parameter int MAX_KERNEL   = 64,
    parameter int MAX_CHANNELS = 64,
    parameter int MAX_COLUMNS  = 1024
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_item
);

    localparam int AW = $clog2(MEM_DEPTH);

    logic [STRIDE_W-1:0] r_stride;
    logic [PAD_W-1:0]    r_padding;
    logic [KERN_W-1:0]   r_kernel;
    logic [CHN_W-1:0]    r_channels;
    logic [NCOL_W-1:0]   r_ncol;
    logic [LEN_W-1:0]    r_len;

    logic [STRIDE_W-1:0] eff_s;
    logic [KERN_W-1:0]   eff_k;
    logic [CHN_W-1:0]    eff_nch;
    logic [NCOL_W-1:0]   eff_ncol;
    logic [LEN_W-1:0]    eff_len;

    t_state r_state, n_state;

    t_in_item                r_item;
    logic [ROW_W-1:0]        r_row;
    logic [ROW_W-1:0]        r_chk;
    logic [POS_W-1:0]        r_pos;
    logic                    r_err;
    logic                    r_drop;
    logic [NCOL_W-1:0]       r_col;
    logic [CS_W-1:0]         r_cs;
    logic [FULL_W-1:0]       r_crow;
    logic [POS_W-1:0]        r_kk;
    logic [FULL_W-1:0]       r_addr;
    logic signed [ACC_W-1:0] r_acc;
    logic [SAMPLE_W-1:0]     r_rd_q;
    logic                    r_rd_vld;
    logic                    r_rd_inr;
    logic                    r_out_vld;
    t_out_item               r_out_item;

    logic [SAMPLE_W-1:0] mem [MEM_DEPTH];

    logic                    in_acc;
    logic                    bad_req;
    logic                    drop_ld;
    logic [POS_W-1:0]        pos_in;
    logic                    div_start;
    logic                    div_done;
    logic [POS_W-1:0]        div_quot;
    logic [NCOL_W-1:0]       ncol_m1;
    logic [POS_W-1:0]        kk_init;
    logic [POS_W-1:0]        kk_step;
    logic [FULL_W-1:0]       ld_full;
    logic                    wr_en;
    logic                    rd_en;
    logic                    out_load;
    logic signed [SUM_W-1:0] sum_sat;

    // effective sizes
    always_comb begin
        eff_s = r_stride;
        if (r_stride == '0) begin
            eff_s = STRIDE_W'(1);
        end else if (32'(r_stride) > STRIDE_MAX) begin
            eff_s = STRIDE_W'(STRIDE_MAX);
        end
        eff_k = r_kernel;
        if (r_kernel == '0) begin
            eff_k = KERN_W'(1);
        end else if (32'(r_kernel) > MAX_KERNEL) begin
            eff_k = KERN_W'(MAX_KERNEL);
        end
        eff_nch = r_channels;
        if (r_channels == '0) begin
            eff_nch = CHN_W'(1);
        end else if (32'(r_channels) > MAX_CHANNELS) begin
            eff_nch = CHN_W'(MAX_CHANNELS);
        end
        eff_ncol = r_ncol;
        if (r_ncol == '0) begin
            eff_ncol = NCOL_W'(1);
        end else if (32'(r_ncol) > MAX_COLUMNS) begin
            eff_ncol = NCOL_W'(MAX_COLUMNS);
        end
        eff_len = (r_len == '0) ? LEN_W'(1) : r_len;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stride   <= STRIDE_W'(1);
            r_padding  <= '0;
            r_kernel   <= KERN_W'(1);
            r_channels <= CHN_W'(1);
            r_ncol     <= NCOL_W'(1);
            r_len      <= LEN_W'(1);
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_STRIDE:      r_stride   <= i_cfg_data[STRIDE_W-1:0];
                CFG_PADDING:     r_padding  <= i_cfg_data[PAD_W-1:0];
                CFG_KERNEL_SIZE: r_kernel   <= i_cfg_data[KERN_W-1:0];
                CFG_CHANNELS:    r_channels <= i_cfg_data[CHN_W-1:0];
                CFG_NUM_COLUMNS: r_ncol     <= i_cfg_data[NCOL_W-1:0];
                CFG_OUT_LENGTH:  r_len      <= i_cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && (r_state == S_IDLE);

    assign bad_req   = ({1'b0, i_in_item.channel} >= eff_nch) || (i_in_item.out_time >= eff_len);
    assign drop_ld   = ({1'b0, i_in_item.column_index} >= eff_ncol)
                       || ({1'b0, i_in_item.channel} >= eff_nch)
                       || ({1'b0, i_in_item.tap} >= eff_k);
    assign pos_in    = POS_W'(i_in_item.out_time) + POS_W'(r_padding);
    assign div_start = in_acc && (i_in_item.mode == MODE_COMPUTE) && !bad_req;

    c2i_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (pos_in),
        .i_divisor  (eff_s),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    assign ncol_m1 = eff_ncol - 1'b1;
    assign kk_init = r_pos - r_cs[POS_W-1:0];
    assign kk_step = r_kk + POS_W'(eff_s);
    assign ld_full = FULL_W'(r_item.column_index) * FULL_W'(r_row)
                     + FULL_W'(r_chk) + FULL_W'(r_item.tap);
    assign wr_en   = (r_state == S_LOAD) && !r_drop && (ld_full < FULL_W'(MEM_DEPTH));
    assign rd_en   = (r_state == S_RUN);
    assign out_load = (r_state == S_DONE) && (!r_out_vld || !i_out_stall);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_in_item.mode == MODE_LOAD) begin
                        n_state = S_LOAD;
                    end else if (bad_req) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_DIV;
                    end
                end
            end
            S_LOAD:  n_state = S_IDLE;
            S_DIV: begin
                if (div_done) begin
                    n_state = S_MUL;
                end
            end
            S_MUL:   n_state = S_ADDR;
            S_ADDR: begin
                n_state = (kk_init >= POS_W'(eff_k)) ? S_DRAIN : S_RUN;
            end
            S_RUN: begin
                if ((r_col == '0) || (kk_step >= POS_W'(eff_k))) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: n_state = S_DONE;
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_rd_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= rd_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_item <= i_in_item;
            r_row  <= ROW_W'(eff_nch) * ROW_W'(eff_k);
            r_chk  <= ROW_W'(i_in_item.channel) * ROW_W'(eff_k);
            r_pos  <= pos_in;
            r_err  <= bad_req;
            r_drop <= drop_ld;
        end
        if ((r_state == S_DIV) && div_done) begin
            r_col <= (div_quot > POS_W'(ncol_m1)) ? ncol_m1 : div_quot[NCOL_W-1:0];
        end
        if (r_state == S_MUL) begin
            r_cs   <= CS_W'(r_col) * CS_W'(eff_s);
            r_crow <= FULL_W'(r_col) * FULL_W'(r_row);
        end
        if (r_state == S_ADDR) begin
            r_kk   <= kk_init;
            r_addr <= r_crow + FULL_W'(r_chk) + FULL_W'(kk_init);
        end
        if (r_state == S_RUN) begin
            r_kk   <= kk_step;
            r_addr <= r_addr + FULL_W'(eff_s) - FULL_W'(r_row);
            r_col  <= r_col - 1'b1;
        end
        r_rd_inr <= (r_addr < FULL_W'(MEM_DEPTH));
        if (in_acc) begin
            r_acc <= '0;
        end else if (r_rd_vld && r_rd_inr) begin
            r_acc <= r_acc + ACC_W'($signed(r_rd_q));
        end
    end

    // column store
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[ld_full[AW-1:0]] <= r_item.sample;
        end
        if (rd_en) begin
            r_rd_q <= mem[r_addr[AW-1:0]];
        end
    end

    always_comb begin
        if (r_err) begin
            sum_sat = '0;
        end else if (r_acc > ACC_SUM_HI) begin
            sum_sat = ACC_SUM_HI[SUM_W-1:0];
        end else if (r_acc < ACC_SUM_LO) begin
            sum_sat = ACC_SUM_LO[SUM_W-1:0];
        end else begin
            sum_sat = r_acc[SUM_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_load) begin
            r_out_vld <= 1'b1;
        end else if (r_out_vld && !i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_item.sum         <= sum_sat;
            r_out_item.range_error <= r_err;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out_item;

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state != S_IDLE))
        else $error("accepted item did not start work");

    a_read_from_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld |-> ($past(r_state) == S_RUN))
        else $error("store read outside tap loop");

    a_tap_in_kernel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> (r_kk < POS_W'(eff_k)))
        else $error("tap index past kernel");

    a_error_zero_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.range_error) |-> (o_out_item.sum == '0))
        else $error("error item with nonzero sum");

endmodule

`default_nettype wire

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the 1-D col2im overlap-add block. A queue of load
// and output-request items feeds a clocked driver; a clocked monitor compares
// each output item field by field against a cycle-free predictor of the
// column store and the overlap-add sum. Several register settings are run,
// clamped and extreme values among them, with random idle and stall bursts.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import c2i_pkg::*;

    localparam int STORE_DEPTH   = 4096;
    localparam int KERNEL_CAP    = 64;
    localparam int CHANNEL_CAP   = 64;
    localparam int COLUMN_CAP    = 1024;
    localparam int TIME_MAX      = 65535;
    localparam int SUM_HI        = 2 ** (SUM_W - 1) - 1;
    localparam int SUM_LO        = -(2 ** (SUM_W - 1));
    localparam int IN_W          = $bits(t_in_item);
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES  = 120;
    localparam int TIMEOUT_NS    = 10_000_000;

    typedef enum int {
        SAMPLES_MIXED,
        SAMPLES_MOST_NEG,
        SAMPLES_MOST_POS
    } t_sample_bias;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    t_in_item              i_in_item = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    t_out_item             o_out_item;

    // register copies as written, masked to the register widths
    logic [STRIDE_W-1:0] cfg_stride   = 1;
    logic [PAD_W-1:0]    cfg_padding  = 0;
    logic [KERN_W-1:0]   cfg_kernel   = 1;
    logic [CHN_W-1:0]    cfg_channels = 1;
    logic [NCOL_W-1:0]   cfg_columns  = 1;
    logic [LEN_W-1:0]    cfg_length   = 1;

    logic signed [SAMPLE_W-1:0] col_mem [STORE_DEPTH];
    bit                         planned [STORE_DEPTH];
    int                         win_col  [KERNEL_CAP];
    int                         win_tap  [KERNEL_CAP];
    int                         win_addr [KERNEL_CAP];

    t_in_item     pending_items [$];
    t_out_item    expected_sums [$];
    t_sample_bias sample_bias = SAMPLES_MIXED;
    bit           idle_en = 1'b1;
    int           gap_left = 0;
    int           stall_left = 0;
    int           n_planned = 0;
    int           n_loads = 0;
    int           n_requests = 0;
    int           n_bad = 0;
    int           n_results = 0;
    int           n_settings = 0;
    int           err_count = 0;

    col2im_1d_overlap_add #(
        .MEM_DEPTH    (STORE_DEPTH),
        .MAX_KERNEL   (KERNEL_CAP),
        .MAX_CHANNELS (CHANNEL_CAP),
        .MAX_COLUMNS  (COLUMN_CAP)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    function automatic int clampi(int v, int lo, int hi);
        return (v < lo) ? lo : (v > hi) ? hi : v;
    endfunction

    function automatic int eff_stride();
        return clampi(int'(cfg_stride), 1, STRIDE_MAX);
    endfunction

    function automatic int eff_kernel();
        return clampi(int'(cfg_kernel), 1, KERNEL_CAP);
    endfunction

    function automatic int eff_channels();
        return clampi(int'(cfg_channels), 1, CHANNEL_CAP);
    endfunction

    function automatic int eff_columns();
        return clampi(int'(cfg_columns), 1, COLUMN_CAP);
    endfunction

    function automatic int eff_length();
        return clampi(int'(cfg_length), 1, TIME_MAX);
    endfunction

    // store address of a load, or -1 when the load is dropped
    function automatic int load_addr(t_in_item it);
        int k;
        int nch;
        int a;
        k   = eff_kernel();
        nch = eff_channels();
        if (int'(it.column_index) >= eff_columns() || int'(it.channel) >= nch ||
            int'(it.tap) >= k) begin
            return -1;
        end
        a = int'(it.column_index) * nch * k + int'(it.channel) * k + int'(it.tap);
        return (a < STORE_DEPTH) ? a : -1;
    endfunction

    function automatic bit request_ok(t_in_item it);
        return int'(it.channel) < eff_channels() && int'(it.out_time) < eff_length();
    endfunction

    // columns whose window covers the requested position, with tap and address
    function automatic int covering_taps(int ch, int t);
        int s;
        int k;
        int nch;
        int pos;
        int cmin;
        int cmax;
        int c;
        int n;
        s    = eff_stride();
        k    = eff_kernel();
        nch  = eff_channels();
        pos  = t + int'(cfg_padding);
        cmin = (pos + s >= k) ? (pos + s - k) / s : 0;
        cmax = pos / s;
        if (cmax >= eff_columns()) begin
            cmax = eff_columns() - 1;
        end
        n = 0;
        for (c = cmin; c <= cmax; c++) begin
            win_col[n]  = c;
            win_tap[n]  = pos - c * s;
            win_addr[n] = c * nch * k + ch * k + win_tap[n];
            n++;
        end
        return n;
    endfunction

    function automatic void predict_col2im(t_in_item it);
        int        a;
        int        n;
        int        i;
        int        acc;
        t_out_item res;
        if (it.mode == MODE_LOAD) begin
            n_loads++;
            a = load_addr(it);
            if (a >= 0) begin
                col_mem[a] = it.sample;
            end
        end else begin
            n_requests++;
            res = '0;
            if (!request_ok(it)) begin
                n_bad++;
                res.range_error = 1'b1;
            end else begin
                acc = 0;
                n = covering_taps(int'(it.channel), int'(it.out_time));
                for (i = 0; i < n; i++) begin
                    if (win_addr[i] < STORE_DEPTH) begin
                        acc += col_mem[win_addr[i]];
                    end
                end
                if (acc > SUM_HI) begin
                    acc = SUM_HI;
                end
                if (acc < SUM_LO) begin
                    acc = SUM_LO;
                end
                res.sum = SUM_W'(acc);
            end
            expected_sums.push_back(res);
        end
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        int r;
        r = $urandom_range(0, 9);
        if (sample_bias == SAMPLES_MOST_NEG || r == 0) begin
            return {1'b1, {(SAMPLE_W - 1){1'b0}}};
        end
        if (sample_bias == SAMPLES_MOST_POS || r == 1) begin
            return {1'b0, {(SAMPLE_W - 1){1'b1}}};
        end
        return SAMPLE_W'($urandom);
    endfunction

    function automatic int pick_column();
        int lim;
        lim = eff_columns();
        if ($urandom_range(0, 1) == 0 && lim > 4) begin
            lim = 4;
        end
        return $urandom_range(0, lim - 1);
    endfunction

    function automatic int pick_time();
        int r;
        int hi;
        r = $urandom_range(0, 9);
        if (r < 4) begin
            hi = 3 * (eff_stride() + eff_kernel());
        end else if (r < 8) begin
            hi = eff_columns() * eff_stride() + eff_kernel();
        end else begin
            hi = TIME_MAX;
        end
        if (hi > eff_length() - 1) begin
            hi = eff_length() - 1;
        end
        return $urandom_range(0, hi);
    endfunction

    function automatic t_in_item mk_item(logic mode, int sample, int col, int ch, int tap,
                                         int t);
        t_in_item it;
        it.mode         = mode;
        it.sample       = SAMPLE_W'(sample);
        it.column_index = COL_W'(col);
        it.channel      = CH_W'(ch);
        it.tap          = TAP_W'(tap);
        it.out_time     = TIME_W'(t);
        return it;
    endfunction

    // a request that would read never-loaded entries is preceded by loads of them
    function automatic void queue_item(t_in_item it);
        t_in_item fill;
        int       a;
        int       n;
        int       i;
        if (it.mode == MODE_LOAD) begin
            a = load_addr(it);
            if (a >= 0) begin
                planned[a] = 1'b1;
            end
        end else if (request_ok(it)) begin
            n = covering_taps(int'(it.channel), int'(it.out_time));
            for (i = 0; i < n; i++) begin
                if (win_addr[i] < STORE_DEPTH && !planned[win_addr[i]]) begin
                    fill              = it;
                    fill.mode         = MODE_LOAD;
                    fill.column_index = COL_W'(win_col[i]);
                    fill.tap          = TAP_W'(win_tap[i]);
                    fill.sample       = pick_sample();
                    planned[win_addr[i]] = 1'b1;
                    pending_items.push_back(fill);
                    n_planned++;
                end
            end
        end
        pending_items.push_back(it);
        n_planned++;
    endfunction

    task automatic plan_phase(int n_items);
        t_in_item it;
        int       goal;
        int       r;
        goal = n_planned + n_items;
        while (n_planned < goal) begin
            it = IN_W'({$urandom, $urandom});
            r  = $urandom_range(0, 99);
            if (r < 40) begin
                it.mode         = MODE_LOAD;
                it.column_index = COL_W'(pick_column());
                it.channel      = CH_W'($urandom_range(0, eff_channels() - 1));
                it.tap          = TAP_W'($urandom_range(0, eff_kernel() - 1));
                it.sample       = pick_sample();
            end else if (r < 85) begin
                it.mode     = MODE_COMPUTE;
                it.channel  = CH_W'($urandom_range(0, eff_channels() - 1));
                it.out_time = TIME_W'(pick_time());
            end else if (r < 93) begin
                it.mode = MODE_COMPUTE;
                if (eff_channels() < CHANNEL_CAP && $urandom_range(0, 1) == 0) begin
                    it.channel = CH_W'($urandom_range(eff_channels(), CHANNEL_CAP - 1));
                end else begin
                    it.out_time = TIME_W'($urandom_range(eff_length(), TIME_MAX));
                end
            end
            queue_item(it);
        end
    endtask

    task automatic write_reg(t_cfg_idx idx, int v);
        logic [CFG_DATA_W-1:0] data;
        data = CFG_DATA_W'($urandom);
        case (idx)
            CFG_STRIDE:      data[STRIDE_W-1:0] = STRIDE_W'(v);
            CFG_PADDING:     data[PAD_W-1:0]    = PAD_W'(v);
            CFG_KERNEL_SIZE: data[KERN_W-1:0]   = KERN_W'(v);
            CFG_CHANNELS:    data[CHN_W-1:0]    = CHN_W'(v);
            CFG_NUM_COLUMNS: data[NCOL_W-1:0]   = NCOL_W'(v);
            default:         data               = CFG_DATA_W'(v);
        endcase
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_STRIDE:      cfg_stride   = data[STRIDE_W-1:0];
            CFG_PADDING:     cfg_padding  = data[PAD_W-1:0];
            CFG_KERNEL_SIZE: cfg_kernel   = data[KERN_W-1:0];
            CFG_CHANNELS:    cfg_channels = data[CHN_W-1:0];
            CFG_NUM_COLUMNS: cfg_columns  = data[NCOL_W-1:0];
            default:         cfg_length   = data[LEN_W-1:0];
        endcase
    endtask

    // checked between edges so the driver and monitor have settled
    task automatic wait_idle();
        while (pending_items.size() != 0 || i_in_valid || expected_sums.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_phase(int s, int p, int k, int ch, int ncol, int len, int n_items,
                             t_sample_bias bias);
        write_reg(CFG_STRIDE, s);
        write_reg(CFG_PADDING, p);
        write_reg(CFG_KERNEL_SIZE, k);
        write_reg(CFG_CHANNELS, ch);
        write_reg(CFG_NUM_COLUMNS, ncol);
        write_reg(CFG_OUT_LENGTH, len);
        n_settings++;
        sample_bias = bias;
        plan_phase(n_items);
        wait_idle();
    endtask

    // input driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                predict_col2im(i_in_item);
            end
            if (!i_in_valid || !o_in_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (idle_en && pending_items.size() != 0 &&
                             $urandom_range(0, 7) == 0) begin
                    gap_left = $urandom_range(0, 15);
                    i_in_valid <= 1'b0;
                end else if (pending_items.size() != 0) begin
                    i_in_item  <= pending_items.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver stall bursts
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if (idle_en && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 15);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // output monitor
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            n_results++;
            if (expected_sums.size() == 0) begin
                $display("%0t: unexpected output item, sum %0d range_error %0b", $time,
                         o_out_item.sum, o_out_item.range_error);
                err_count++;
            end else begin
                want = expected_sums.pop_front();
                if (o_out_item.sum !== want.sum) begin
                    $display("%0t: sum mismatch, expected %0d actual %0d", $time,
                             want.sum, o_out_item.sum);
                    err_count++;
                end
                if (o_out_item.range_error !== want.range_error) begin
                    $display("%0t: range_error mismatch, expected %0b actual %0b", $time,
                             want.range_error, o_out_item.range_error);
                    err_count++;
                end
            end
        end
    end

    initial begin
        #(TIMEOUT_NS);
        $display("timeout with %0d output items still expected", expected_sums.size());
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset sizes: extreme samples, each reason for a dropped load, bad requests
        queue_item(mk_item(MODE_LOAD, -32768, 0, 0, 0, 0));
        queue_item(mk_item(MODE_COMPUTE, 0, 0, 0, 0, 0));
        queue_item(mk_item(MODE_LOAD, 32767, 0, 0, 0, 0));
        queue_item(mk_item(MODE_COMPUTE, 0, 0, 0, 0, 0));
        queue_item(mk_item(MODE_LOAD, 21845, 1023, 0, 0, 0));
        queue_item(mk_item(MODE_LOAD, -1, 0, 63, 0, 0));
        queue_item(mk_item(MODE_LOAD, -2, 0, 0, 63, 0));
        queue_item(mk_item(MODE_COMPUTE, 0, 0, 0, 0, 0));
        queue_item(mk_item(MODE_COMPUTE, 0, 0, 1, 0, 0));
        queue_item(mk_item(MODE_COMPUTE, 0, 0, 0, 0, 1));
        queue_item(mk_item(MODE_COMPUTE, -1, 1023, 63, 63, 65535));
        queue_item(mk_item(MODE_COMPUTE, -21846, 1023, 0, 63, 0));
        wait_idle();

        run_phase(2, 1, 3, 2, 4, 12, 70, SAMPLES_MIXED);
        run_phase(1, 0, 5, 3, 6, 20, 70, SAMPLES_MIXED);
        run_phase(3, 5, 2, 4, 8, 40, 70, SAMPLES_MIXED);
        run_phase(64, 63, 64, 1, 64, 65535, 50, SAMPLES_MIXED);
        // zero register values clamp to one, but padding stays zero
        run_phase(0, 0, 0, 0, 0, 0, 25, SAMPLES_MIXED);
        // oversize values clamp, only column zero fits in the store
        run_phase(127, 7, 127, 127, 2047, 65535, 50, SAMPLES_MIXED);
        run_phase(64, 0, 2, 1, 1024, 65535, 60, SAMPLES_MIXED);
        // full 64-tap overlap reaching the most negative sum
        run_phase(1, 0, 64, 1, 64, 128, 130, SAMPLES_MOST_NEG);
        idle_en = 1'b0;
        run_phase(2, 2, 4, 2, 16, 64, 110, SAMPLES_MIXED);

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("checked %0d output items from %0d loads and %0d output requests (%0d bad)",
                 n_results, n_loads, n_requests, n_bad);
        $display("ran %0d register settings plus the reset sizes, clamped values included",
                 n_settings);
        if (err_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

`default_nettype wire
